FILE: design/stereo_level_meter_channel_select_core_assert.svh
// assertion macros for the level meter core
`ifndef STEREO_LEVEL_METER_CHANNEL_SELECT_CORE_ASSERT_SVH
`define STEREO_LEVEL_METER_CHANNEL_SELECT_CORE_ASSERT_SVH

`ifndef SYNTH
`define SLMCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SLMCS_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SLMCS_ASSERT(lbl, prop, msg)
`define SLMCS_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/slmcs_pkg.sv
`timescale 1ns / 1ps
package slmcs_pkg;

   // block geometry
   localparam int FRAME_LEN = 256;
   localparam int ADDR_W    = 8;
   localparam int CNT_W     = 9;
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 25;

   // shared divider widths
   localparam int DIV_N_W   = 26;
   localparam int DIV_D_W   = 16;
   localparam int DIV_C_W   = 5;

   // register indexes
   localparam logic [7:0] REG_ACTIVE_THRESHOLD    = 8'd0;
   localparam logic [7:0] REG_ENVELOPE_FULL_SCALE = 8'd1;
   localparam logic [7:0] REG_DISPLAY_RANGE       = 8'd2;
   localparam logic [7:0] REG_PEAK_DECAY          = 8'd3;

   // register reset values
   localparam logic [15:0] RST_ACTIVE_THRESHOLD    = 16'd20;
   localparam logic [15:0] RST_ENVELOPE_FULL_SCALE = 16'd5000;
   localparam logic [9:0]  RST_DISPLAY_RANGE       = 10'd100;
   localparam logic [9:0]  RST_PEAK_DECAY          = 10'd2;

   // mono source codes
   localparam logic [1:0] SRC_MIX   = 2'd0;
   localparam logic [1:0] SRC_LEFT  = 2'd1;
   localparam logic [1:0] SRC_RIGHT = 2'd2;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: design/slmcs_ram.sv
`timescale 1ns / 1ps
module slmcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/slmcs_div.sv
`timescale 1ns / 1ps
`include "stereo_level_meter_channel_select_core_assert.svh"
module slmcs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  slmcs_pkg::div_req_type    req,
   output slmcs_pkg::div_rsp_type    rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [slmcs_pkg::DIV_C_W-1:0]       cnt_ff, cnt_in;
   logic [slmcs_pkg::DIV_D_W:0]         rem_ff, rem_in;
   logic [slmcs_pkg::DIV_N_W-1:0]       quot_ff, quot_in;
   logic [slmcs_pkg::DIV_D_W-1:0]       dvs_ff, dvs_in;
   logic [slmcs_pkg::DIV_D_W:0]         shifted;
   logic                                fits;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff[slmcs_pkg::DIV_D_W-1:0], quot_ff[slmcs_pkg::DIV_N_W-1]};
      fits    = (shifted >= {1'b0, dvs_ff});
      if (busy_ff) begin
         rem_in  = fits ? (shifted - {1'b0, dvs_ff}) : shifted;
         quot_in = {quot_ff[slmcs_pkg::DIV_N_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == slmcs_pkg::DIV_C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = slmcs_pkg::DIV_C_W'(slmcs_pkg::DIV_N_W);
         rem_in  = '0;
         quot_in = req.dividend;
         dvs_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

   `SLMCS_NEVER(a_div_start_busy, req.start && busy_ff, "divider started while busy")
   `SLMCS_NEVER(a_div_done_busy, done_ff && busy_ff, "divider done while busy")
   `SLMCS_ASSERT(a_div_done_end, done_ff |-> $past(busy_ff), "done without a run")

endmodule

FILE: design/stereo_level_meter_channel_select_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: left_raw, right_raw; tlast: last_pair
// rsp     | out | rsp_tvalid/tready    | tdata: source, mean abs, peak, level, hold
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
// pairs load at one per cycle into two 256 x 16 sample memories.
// the last pair of a block of at most 256 pairs starts the block finish: seven divides on
// one shared divider, two passes over the stored pairs and two multiplies,
// during which req_tready is low; a longer block is dropped.
// synchronous active high reset; a pending result only stalls the final step.
`include "stereo_level_meter_channel_select_core_assert.svh"
module stereo_level_meter_channel_select_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // left_raw [31:0], right_raw [63:32]
   input  logic        req_tlast,   // last_pair
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // chan_sel [1:0], mono_mean_abs [17:2], abs_peak [33:18],
   // level [43:34], held_level [53:44], zero [55:54]
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_PASS1 = 3'd2;
   localparam logic [2:0] S_SEL   = 3'd3;
   localparam logic [2:0] S_PASS2 = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [2:0] OP_LM    = 3'd0;
   localparam logic [2:0] OP_RM    = 3'd1;
   localparam logic [2:0] OP_LA    = 3'd2;
   localparam logic [2:0] OP_RA    = 3'd3;
   localparam logic [2:0] OP_MAVG  = 3'd4;
   localparam logic [2:0] OP_LEVEL = 3'd5;
   localparam logic [2:0] OP_PEAK  = 3'd6;

   localparam int NW = slmcs_pkg::DIV_N_W;

   // config registers
   logic [15:0] thr_ff, fs_ff;
   logic [9:0]  dr_ff, decay_ff;

   // control
   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       issued_ff, issued_in;
   logic [slmcs_pkg::CNT_W-1:0] count_ff, count_in;
   logic [slmcs_pkg::CNT_W-1:0] addr_ff, addr_in;
   logic       rd_vld_ff, rd_vld_in, rd_last_ff, rd_last_in;
   logic       ovf_ff, ovf_in;
   logic [9:0] held_ff, held_in;
   logic       rsp_vld_ff, rsp_vld_in;

   // datapath
   logic signed [slmcs_pkg::SUM_W-1:0] lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic signed [15:0] lm_ff, lm_in, rm_ff, rm_in;
   logic [slmcs_pkg::SUM_W-1:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [15:0] la_ff, la_in, ra_ff, ra_in, peak_ff, peak_in, mavg_ff, mavg_in;
   logic [1:0]  src_ff, src_in;
   logic [NW-1:0] prod_ff, prod_in;
   logic [9:0]  level_ff, level_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   logic req_acc;
   logic signed [15:0] l_in, r_in, l_rd, r_rd;
   logic [7:0] ram_wr_addr, ram_rd_addr;
   logic       ram_wr_en;
   slmcs_pkg::div_req_type div_req;
   slmcs_pkg::div_rsp_type div_rsp;

   logic [NW-1:0] lsum_x, rsum_x, mag_l, mag_r, q;
   logic [15:0]   fs1;
   logic [9:0]    q_clamp;
   logic signed [16:0] dl, dr_c;
   logic [16:0]   abs_l, abs_r;
   logic signed [17:0] mix_s, mix_h, c_sel;
   logic [17:0]   abs_c;
   logic signed [10:0] held_dec;
   logic [9:0]    new_held;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign l_in       = req_tdata[31:16];
   assign r_in       = req_tdata[63:48];

   // sample stores
   assign ram_wr_en   = req_acc && (count_ff < slmcs_pkg::CNT_W'(slmcs_pkg::FRAME_LEN));
   assign ram_wr_addr = count_ff[slmcs_pkg::ADDR_W-1:0];
   assign ram_rd_addr = addr_ff[slmcs_pkg::ADDR_W-1:0];

   slmcs_ram #(.WIDTH(slmcs_pkg::SAMPLE_W), .DEPTH(slmcs_pkg::FRAME_LEN)) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (l_in),
      .rd_addr (ram_rd_addr),
      .rd_data (l_rd)
   );

   slmcs_ram #(.WIDTH(slmcs_pkg::SAMPLE_W), .DEPTH(slmcs_pkg::FRAME_LEN)) u_right_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (r_in),
      .rd_addr (ram_rd_addr),
      .rd_data (r_rd)
   );

   slmcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // divider operand selection
   always_comb begin
      lsum_x = NW'(lsum_ff);
      rsum_x = NW'(rsum_ff);
      mag_l  = lsum_ff[slmcs_pkg::SUM_W-1] ? (NW'(0) - lsum_x) : lsum_x;
      mag_r  = rsum_ff[slmcs_pkg::SUM_W-1] ? (NW'(0) - rsum_x) : rsum_x;
      fs1    = (fs_ff == 16'd0) ? 16'd1 : fs_ff;
      div_req.start   = (state_ff == S_DIV) && !issued_ff;
      div_req.divisor = 16'(count_ff);
      unique case (op_ff)
         OP_LM:    div_req.dividend = mag_l;
         OP_RM:    div_req.dividend = mag_r;
         OP_LA:    div_req.dividend = NW'(acc_a_ff);
         OP_RA:    div_req.dividend = NW'(acc_b_ff);
         OP_MAVG:  div_req.dividend = NW'(acc_a_ff);
         default: begin
            div_req.dividend = prod_ff;
            div_req.divisor  = fs1;
         end
      endcase
   end

   // pass datapath
   always_comb begin
      q        = div_rsp.quotient;
      q_clamp  = (q > NW'(dr_ff)) ? dr_ff : q[9:0];
      dl       = 17'(l_rd) - 17'(lm_ff);
      dr_c     = 17'(r_rd) - 17'(rm_ff);
      abs_l    = dl[16] ? (17'd0 - dl) : dl;
      abs_r    = dr_c[16] ? (17'd0 - dr_c) : dr_c;
      mix_s    = 18'(dl) + 18'(dr_c);
      // halve toward zero: bias negative sums by one before the shift
      mix_h    = $signed(mix_s + 18'(mix_s[17])) >>> 1;
      unique case (src_ff)
         slmcs_pkg::SRC_LEFT:  c_sel = 18'(dl);
         slmcs_pkg::SRC_RIGHT: c_sel = 18'(dr_c);
         default:              c_sel = mix_h;
      endcase
      abs_c    = c_sel[17] ? (18'd0 - c_sel) : c_sel;
      held_dec = 11'(held_ff) - 11'(decay_ff);
      if (held_dec[10]) begin
         new_held = 10'd0;
      end else if (held_dec[9:0] > dr_ff) begin
         new_held = dr_ff;
      end else begin
         new_held = held_dec[9:0];
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      issued_in   = issued_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      rd_vld_in   = 1'b0;
      rd_last_in  = 1'b0;
      ovf_in      = ovf_ff;
      held_in     = held_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      lsum_in     = lsum_ff;
      rsum_in     = rsum_ff;
      lm_in       = lm_ff;
      rm_in       = rm_ff;
      acc_a_in    = acc_a_ff;
      acc_b_in    = acc_b_ff;
      la_in       = la_ff;
      ra_in       = ra_ff;
      peak_in     = peak_ff;
      mavg_in     = mavg_ff;
      src_in      = src_ff;
      prod_in     = prod_ff;
      level_in    = level_ff;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (ram_wr_en) begin
                  lsum_in  = lsum_ff + slmcs_pkg::SUM_W'(l_in);
                  rsum_in  = rsum_ff + slmcs_pkg::SUM_W'(r_in);
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  if (!ram_wr_en || ovf_ff) begin
                     count_in = '0;
                     lsum_in  = '0;
                     rsum_in  = '0;
                     ovf_in   = 1'b0;
                  end else begin
                     state_in = S_DIV;
                     op_in    = OP_LM;
                  end
               end
            end
         end
         S_DIV: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (div_rsp.done) begin
               issued_in = 1'b0;
               unique case (op_ff)
                  OP_LM: begin
                     lm_in = lsum_ff[slmcs_pkg::SUM_W-1] ? (16'd0 - q[15:0]) : q[15:0];
                     op_in = OP_RM;
                  end
                  OP_RM: begin
                     rm_in    = rsum_ff[slmcs_pkg::SUM_W-1] ? (16'd0 - q[15:0]) : q[15:0];
                     state_in = S_PASS1;
                     addr_in  = '0;
                     acc_a_in = '0;
                     acc_b_in = '0;
                  end
                  OP_LA: begin
                     la_in = q[15:0];
                     op_in = OP_RA;
                  end
                  OP_RA: begin
                     ra_in    = q[15:0];
                     state_in = S_SEL;
                  end
                  OP_MAVG: begin
                     mavg_in  = q[15:0];
                     op_in    = OP_LEVEL;
                     state_in = S_MUL;
                  end
                  OP_LEVEL: begin
                     level_in = q_clamp;
                     op_in    = OP_PEAK;
                     state_in = S_MUL;
                  end
                  default: begin
                     // peak scaled: raise or decay the hold
                     held_in  = (q_clamp > held_ff) ? q_clamp : new_held;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PASS1, S_PASS2: begin
            if (addr_ff < count_ff) begin
               addr_in    = addr_ff + 1'b1;
               rd_vld_in  = 1'b1;
               rd_last_in = (addr_ff == count_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               if (state_ff == S_PASS1) begin
                  acc_a_in = acc_a_ff + slmcs_pkg::SUM_W'(abs_l);
                  acc_b_in = acc_b_ff + slmcs_pkg::SUM_W'(abs_r);
               end else begin
                  acc_a_in = acc_a_ff + slmcs_pkg::SUM_W'(abs_c);
                  if (abs_c[15:0] > peak_ff) begin
                     peak_in = abs_c[15:0];
                  end
               end
               if (rd_last_ff) begin
                  state_in = S_DIV;
                  op_in    = (state_ff == S_PASS1) ? OP_LA : OP_MAVG;
               end
            end
         end
         S_SEL: begin
            // silent channel loses, a channel over twice the other wins
            if (la_ff < thr_ff && ra_ff >= thr_ff) begin
               src_in = slmcs_pkg::SRC_RIGHT;
            end else if (ra_ff < thr_ff && la_ff >= thr_ff) begin
               src_in = slmcs_pkg::SRC_LEFT;
            end else if (17'(la_ff) > {ra_ff, 1'b0}) begin
               src_in = slmcs_pkg::SRC_LEFT;
            end else if (17'(ra_ff) > {la_ff, 1'b0}) begin
               src_in = slmcs_pkg::SRC_RIGHT;
            end else begin
               src_in = slmcs_pkg::SRC_MIX;
            end
            state_in = S_PASS2;
            addr_in  = '0;
            acc_a_in = '0;
            peak_in  = '0;
         end
         S_MUL: begin
            prod_in  = NW'(((op_ff == OP_LEVEL) ? mavg_ff : peak_ff) * dr_ff);
            state_in = S_DIV;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {2'b00, held_ff, level_ff, peak_ff, mavg_ff, src_ff};
               state_in    = S_LOAD;
               count_in    = '0;
               lsum_in     = '0;
               rsum_in     = '0;
               ovf_in      = 1'b0;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         op_ff      <= OP_LM;
         issued_ff  <= 1'b0;
         count_ff   <= '0;
         addr_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         held_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         lsum_ff    <= '0;
         rsum_ff    <= '0;
         thr_ff     <= slmcs_pkg::RST_ACTIVE_THRESHOLD;
         fs_ff      <= slmcs_pkg::RST_ENVELOPE_FULL_SCALE;
         dr_ff      <= slmcs_pkg::RST_DISPLAY_RANGE;
         decay_ff   <= slmcs_pkg::RST_PEAK_DECAY;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         issued_ff  <= issued_in;
         count_ff   <= count_in;
         addr_ff    <= addr_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         ovf_ff     <= ovf_in;
         held_ff    <= held_in;
         rsp_vld_ff <= rsp_vld_in;
         lsum_ff    <= lsum_in;
         rsum_ff    <= rsum_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               slmcs_pkg::REG_ACTIVE_THRESHOLD:    thr_ff   <= csr_data;
               slmcs_pkg::REG_ENVELOPE_FULL_SCALE: fs_ff    <= csr_data;
               slmcs_pkg::REG_DISPLAY_RANGE:       dr_ff    <= csr_data[9:0];
               slmcs_pkg::REG_PEAK_DECAY:          decay_ff <= csr_data[9:0];
               default: ;
            endcase
         end
      end
      lm_ff       <= lm_in;
      rm_ff       <= rm_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      la_ff       <= la_in;
      ra_ff       <= ra_in;
      peak_ff     <= peak_in;
      mavg_ff     <= mavg_in;
      src_ff      <= src_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SLMCS_NEVER(a_count_range, count_ff > slmcs_pkg::CNT_W'(slmcs_pkg::FRAME_LEN), "pair count past frame")
   `SLMCS_NEVER(a_hold_range, rsp_vld_ff && (rsp_data_ff[53:44] > dr_ff), "peak hold above range")
   `SLMCS_NEVER(a_level_range, rsp_vld_ff && (rsp_data_ff[43:34] > dr_ff), "level above range")
   `SLMCS_NEVER(a_pass_empty, (state_ff == S_DIV) && (count_ff == '0), "finish with no pairs")

endmodule

FILE: bench/tb_stereo_level_meter_channel_select_core.sv
`timescale 1ns / 1ps
module tb_stereo_level_meter_channel_select_core;

   localparam logic [7:0] REG_UNUSED = 8'd9;
   localparam int QUIET_CYCLES = 800;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      logic [1:0]  src;
      logic [15:0] mean_abs;
      logic [15:0] peak;
      logic [9:0]  level;
      logic [9:0]  hold;
   } meter_word_type;

   // scoreboard: block accumulator and predicted meter words
   class meter_board;
      int unsigned    thr, full_scale, disp_range, decay;
      int             left_buf [slmcs_pkg::FRAME_LEN];
      int             right_buf[slmcs_pkg::FRAME_LEN];
      int             count;
      longint         lsum, rsum;
      bit             too_long;
      int             held;
      meter_word_type pending[$];
      int             errors;

      function new();
         thr = slmcs_pkg::RST_ACTIVE_THRESHOLD;
         full_scale = slmcs_pkg::RST_ENVELOPE_FULL_SCALE;
         disp_range = slmcs_pkg::RST_DISPLAY_RANGE;
         decay = slmcs_pkg::RST_PEAK_DECAY;
         count = 0; lsum = 0; rsum = 0; too_long = 0; held = 0; errors = 0;
      endfunction

      function void set_reg(logic [7:0] idx, logic [15:0] val);
         case (idx)
            slmcs_pkg::REG_ACTIVE_THRESHOLD:    thr = val;
            slmcs_pkg::REG_ENVELOPE_FULL_SCALE: full_scale = val;
            slmcs_pkg::REG_DISPLAY_RANGE:       disp_range = val[9:0];
            slmcs_pkg::REG_PEAK_DECAY:          decay = val[9:0];
            default: ;
         endcase
      endfunction

      function int scale_to_range(longint v);
         longint fs, s;
         fs = (full_scale == 0) ? 1 : full_scale;
         s = v * longint'(disp_range) / fs;
         if (s > disp_range) s = disp_range;
         if (s < 0) s = 0;
         return int'(s);
      endfunction

      function void restart_block();
         count = 0; lsum = 0; rsum = 0; too_long = 0;
      endfunction

      // note one accepted sample pair, predict a word when the block closes
      function void note_pair(logic [31:0] lraw, logic [31:0] rraw, logic last);
         int             l, r, pv, h;
         longint         lm, rm, la, ra, lc, rc, c, a, msum, mpeak, mavg;
         logic [1:0]     src;
         meter_word_type w;
         l = int'($signed(lraw[31:16]));
         r = int'($signed(rraw[31:16]));
         if (count >= slmcs_pkg::FRAME_LEN) too_long = 1;
         else begin
            left_buf[count] = l; right_buf[count] = r;
            lsum += l; rsum += r; count++;
         end
         if (!last) return;
         if (too_long || count == 0) begin
            restart_block();
            return;
         end
         lm = lsum / count; rm = rsum / count;
         la = 0; ra = 0;
         for (int i = 0; i < count; i++) begin
            lc = left_buf[i] - lm; rc = right_buf[i] - rm;
            la += (lc < 0) ? -lc : lc;
            ra += (rc < 0) ? -rc : rc;
         end
         la /= count; ra /= count;
         // silent channel loses, then twice-as-loud wins, else mix
         if (la < thr && ra >= thr) src = slmcs_pkg::SRC_RIGHT;
         else if (ra < thr && la >= thr) src = slmcs_pkg::SRC_LEFT;
         else if (la > ra * 2) src = slmcs_pkg::SRC_LEFT;
         else if (ra > la * 2) src = slmcs_pkg::SRC_RIGHT;
         else src = slmcs_pkg::SRC_MIX;
         msum = 0; mpeak = 0;
         for (int i = 0; i < count; i++) begin
            lc = left_buf[i] - lm; rc = right_buf[i] - rm;
            c = (src == slmcs_pkg::SRC_LEFT) ? lc :
                (src == slmcs_pkg::SRC_RIGHT) ? rc : (lc + rc) / 2;
            a = (c < 0) ? -c : c;
            if (a > mpeak) mpeak = a;
            msum += a;
         end
         mavg = msum / count;
         pv = scale_to_range(mpeak);
         // peak hold rises at once, otherwise decays and clamps
         if (pv > held) held = pv;
         else begin
            h = held - int'(decay);
            if (h > int'(disp_range)) h = int'(disp_range);
            if (h < 0) h = 0;
            held = h;
         end
         w.src = src; w.mean_abs = mavg[15:0]; w.peak = mpeak[15:0];
         w.level = 10'(scale_to_range(mavg)); w.hold = 10'(held);
         pending.push_back(w);
         restart_block();
      endfunction

      function void check_word(logic [55:0] d);
         meter_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $realtime, d);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (d[1:0] !== w.src) begin
            $display("%0t: channel select expected %0d actual %0d",
                     $realtime, w.src, d[1:0]);
            errors++;
         end
         if (d[17:2] !== w.mean_abs) begin
            $display("%0t: mono_mean_abs expected %0d actual %0d",
                     $realtime, w.mean_abs, d[17:2]);
            errors++;
         end
         if (d[33:18] !== w.peak) begin
            $display("%0t: block peak expected %0d actual %0d", $realtime, w.peak, d[33:18]);
            errors++;
         end
         if (d[43:34] !== w.level) begin
            $display("%0t: level expected %0d actual %0d", $realtime, w.level, d[43:34]);
            errors++;
         end
         if (d[53:44] !== w.hold) begin
            $display("%0t: held level expected %0d actual %0d", $realtime, w.hold, d[53:44]);
            errors++;
         end
         if (d[55:54] !== 2'b00) begin
            $display("%0t: pad bits expected 0 actual %0d", $realtime, d[55:54]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   meter_board board = new();
   bit         idling_on = 1;
   int         stall_count = 0;

   stereo_level_meter_channel_select_core dut (.*);

   // 12 ns clock
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // result side back-pressure
   always @(negedge clock)
      rsp_tready = !idling_on || ($urandom_range(99) >= 22);

   // result monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            stall_count <= 0;
         else if (stall_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else
            stall_count <= stall_count + 1;
      end
   end

   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = val;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic send_pair(logic [31:0] l, logic [31:0] r, logic last);
      @(negedge clock);
      // idle for a random number of cycles, about 22 in a hundred
      while (idling_on && $urandom_range(99) < 22) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1; req_tdata = {r, l}; req_tlast = last;
      do @(posedge clock); while (!req_tready);
      board.note_pair(l, r, last);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // sample with a dc offset and bounded swing, random low bits
   function automatic logic [31:0] make_sample(int swing, int offset);
      int v;
      v = offset + $signed($urandom_range(2 * swing)) - swing;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return {v[15:0], 16'($urandom)};
   endfunction

   function automatic int pick_swing();
      case ($urandom_range(4))
         0: return 0;
         1: return $urandom_range(30);
         2: return $urandom_range(400);
         3: return $urandom_range(8000);
         default: return 32768;
      endcase
   endfunction

   task automatic send_block(int n);
      int lsw, rsw, loff, roff;
      lsw = pick_swing(); rsw = pick_swing();
      loff = $signed($urandom_range(4000)) - 2000;
      roff = $signed($urandom_range(4000)) - 2000;
      for (int i = 0; i < n; i++)
         send_pair(make_sample(lsw, loff), make_sample(rsw, roff), i == n - 1);
   endtask

   task automatic settle();
      release_req();
      wait (board.pending.size() == 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int t, int fs, int dr, int dc);
      write_reg(slmcs_pkg::REG_ACTIVE_THRESHOLD, 16'(t));
      write_reg(slmcs_pkg::REG_ENVELOPE_FULL_SCALE, 16'(fs));
      write_reg(slmcs_pkg::REG_DISPLAY_RANGE, 16'(dr));
      write_reg(slmcs_pkg::REG_PEAK_DECAY, 16'(dc));
   endtask

   // random phase: mostly short blocks, now and then full or overlong ones
   task automatic random_phase(int pairs);
      int sent, n;
      sent = 0;
      while (sent < pairs) begin
         case ($urandom_range(19))
            0:       n = slmcs_pkg::FRAME_LEN;
            1:       n = slmcs_pkg::FRAME_LEN + $urandom_range(1, 3);
            2, 3:    n = 1;
            default: n = $urandom_range(2, 16);
         endcase
         if (n > pairs - sent) n = pairs - sent;
         send_block(n);
         sent += n;
      end
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes and channel choices
      configure(slmcs_pkg::RST_ACTIVE_THRESHOLD, slmcs_pkg::RST_ENVELOPE_FULL_SCALE,
                slmcs_pkg::RST_DISPLAY_RANGE, slmcs_pkg::RST_PEAK_DECAY);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_pair(32'h0000_0000, 32'h0000_0000, 0);
      send_pair(32'h0000_FFFF, 32'hFFFF_0000, 1);
      send_pair(32'h4000_1234, 32'h0001_0000, 0);
      send_pair(32'hC000_5678, 32'hFFFF_0000, 1);
      send_pair(32'h0001_0000, 32'h3000_0000, 0);
      send_pair(32'h0000_0000, 32'hD000_0000, 1);
      send_pair(32'h1000_0000, 32'h0A00_0000, 0);
      send_pair(32'hF000_0000, 32'hF600_0000, 1);
      send_pair(32'h7FFF_0000, 32'h7FFF_0000, 1);
      send_pair(32'h7FFF_0000, 32'h7FFF_0000, 1);
      settle();

      // random phases over several register settings
      random_phase(265);
      configure(0, 1, 1000, 0);
      random_phase(265);
      idling_on = 0;
      configure(65535, 65535, 1, 1000);
      random_phase(265);
      idling_on = 1;
      write_reg(REG_UNUSED, 16'($urandom));
      configure($urandom_range(200), 0, 0, $urandom_range(1000));
      random_phase(265);
      configure(300, 20000, 1023, 5);
      random_phase(265);
      configure($urandom_range(65535), $urandom_range(1, 65535),
                $urandom_range(1, 1000), $urandom_range(1000));
      random_phase(265);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
